@@ hdl/tscf_pkg.sv @@
package tscf_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS        = 3'd5;

    // Character codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_QMARK      = 8'h3F;
    localparam logic [7:0] CH_I          = 8'h49;
    localparam logic [7:0] CH_CARET      = 8'h5E;
    localparam logic [7:0] CH_DEL        = 8'h7F;
    localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CARET_OFFSET  = 8'h40;

    // Classified item handed from the front end to the output sequencer
    typedef struct packed {
        logic       num;       // line number goes first
        logic [1:0] tail_cnt;  // bytes after the number, 0..2
        logic [7:0] tail0;
        logic [7:0] tail1;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_HEAD,
        ST_PAD,
        ST_DIGIT,
        ST_TAB,
        ST_TAIL
    } back_state_t;

endpackage

@@ hdl/tscf_front.sv @@
module tscf_front #(
    parameter int COUNT_DIGITS = 8,
    parameter int MIN_WIDTH    = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [tscf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic                                cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          in_byte,
    input  logic                                queue_full,
    output logic                                push,
    output tscf_pkg::cmd_t                      cmd,
    output logic [4*COUNT_DIGITS-1:0]           num_bcd,
    output logic [$clog2(COUNT_DIGITS+1)-1:0]   num_sig,
    output logic [$clog2(MIN_WIDTH+1)-1:0]      num_pad
);

    localparam int BCD_W = 4 * COUNT_DIGITS;
    localparam int SIG_W = $clog2(COUNT_DIGITS + 1);
    localparam int PAD_W = $clog2(MIN_WIDTH + 1);

    logic number_nonblank_reg, number_all_reg, squeeze_blank_reg;
    logic show_nonprinting_reg, show_tabs_reg, show_ends_reg;

    logic [BCD_W-1:0] count_reg, count_next;
    logic             prev_nl_reg, prev_nl_next;
    logic [1:0]       run_reg, run_next;

    logic             is_nl, is_tab, drop, do_num, count_is_one, accept;
    logic [1:0]       run_inc;
    logic [BCD_W-1:0] count_inc;
    logic             all_nine, carry;
    logic [3:0]       digit;
    logic [SIG_W-1:0] sig;
    logic [PAD_W-1:0] pad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_nonblank_reg  <= 1'b0;
            number_all_reg       <= 1'b0;
            squeeze_blank_reg    <= 1'b0;
            show_nonprinting_reg <= 1'b0;
            show_tabs_reg        <= 1'b0;
            show_ends_reg        <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                tscf_pkg::REG_NUMBER_NONBLANK:  number_nonblank_reg  <= cfg_data;
                tscf_pkg::REG_NUMBER_ALL:       number_all_reg       <= cfg_data;
                tscf_pkg::REG_SQUEEZE_BLANK:    squeeze_blank_reg    <= cfg_data;
                tscf_pkg::REG_SHOW_NONPRINTING: show_nonprinting_reg <= cfg_data;
                tscf_pkg::REG_SHOW_TABS:        show_tabs_reg        <= cfg_data;
                tscf_pkg::REG_SHOW_ENDS:        show_ends_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Number width and saturating decimal increment
    always_comb
    begin
        sig       = SIG_W'(1);
        all_nine  = 1'b1;
        carry     = 1'b1;
        count_inc = count_reg;
        for (int i = 0; i < COUNT_DIGITS; i++)
        begin
            digit = count_reg[4*i +: 4];
            if (digit != 4'd0)
                sig = SIG_W'(i + 1);
            if (digit != 4'd9)
                all_nine = 1'b0;
            if (carry)
                count_inc[4*i +: 4] = (digit >= 4'd9) ? 4'd0 : digit + 4'd1;
            carry = carry && (digit >= 4'd9);
        end
        if (all_nine)
            count_inc = count_reg;
        if (int'(sig) < MIN_WIDTH)
            pad = PAD_W'(MIN_WIDTH - int'(sig));
        else
            pad = '0;
    end

    always_comb
    begin
        is_nl        = (in_byte == tscf_pkg::CH_NL);
        is_tab       = (in_byte == tscf_pkg::CH_TAB);
        count_is_one = (count_reg == BCD_W'(1));

        // A newline that takes the run past two is dropped outright
        drop    = squeeze_blank_reg && is_nl && (run_reg >= 2'd2);
        run_inc = (squeeze_blank_reg && is_nl) ? run_reg + 2'd1 : run_reg;

        if (number_nonblank_reg)
            do_num = !is_nl && (prev_nl_reg || count_is_one);
        else
            do_num = number_all_reg && prev_nl_reg;

        cmd.tail0    = in_byte;
        cmd.tail1    = in_byte;
        cmd.tail_cnt = 2'd0;
        if (is_tab)
        begin
            if (show_tabs_reg)
            begin
                cmd.tail0    = tscf_pkg::CH_CARET;
                cmd.tail1    = tscf_pkg::CH_I;
                cmd.tail_cnt = 2'd2;
            end
            else
            begin
                cmd.tail0    = tscf_pkg::CH_TAB;
                cmd.tail_cnt = 2'd1;
            end
        end
        else if (is_nl)
        begin
            if (run_inc <= 2'd2)
            begin
                if (show_ends_reg)
                begin
                    cmd.tail0    = tscf_pkg::CH_DOLLAR;
                    cmd.tail1    = tscf_pkg::CH_NL;
                    cmd.tail_cnt = 2'd2;
                end
                else
                begin
                    cmd.tail0    = tscf_pkg::CH_NL;
                    cmd.tail_cnt = 2'd1;
                end
            end
        end
        else if (show_nonprinting_reg && in_byte == tscf_pkg::CH_DEL)
        begin
            cmd.tail0    = tscf_pkg::CH_CARET;
            cmd.tail1    = tscf_pkg::CH_QMARK;
            cmd.tail_cnt = 2'd2;
        end
        else if (show_nonprinting_reg && in_byte < tscf_pkg::CH_CTRL_LIMIT)
        begin
            cmd.tail0    = tscf_pkg::CH_CARET;
            cmd.tail1    = in_byte + tscf_pkg::CARET_OFFSET;
            cmd.tail_cnt = 2'd2;
        end
        else
        begin
            cmd.tail_cnt = 2'd1;
        end
        cmd.num = do_num;

        if (drop)
        begin
            run_next     = 2'd3;
            prev_nl_next = prev_nl_reg;
            count_next   = count_reg;
        end
        else
        begin
            if ((!is_nl && !is_tab) || (number_nonblank_reg && do_num))
                run_next = 2'd0;
            else
                run_next = run_inc;
            prev_nl_next = is_nl;
            count_next   = do_num ? count_inc : count_reg;
        end
    end

    assign push    = accept && !drop && (do_num || cmd.tail_cnt != 2'd0);
    assign num_bcd = count_reg;
    assign num_sig = sig;
    assign num_pad = pad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= BCD_W'(1);
            prev_nl_reg <= 1'b1;
            run_reg     <= 2'd1;
        end
        else if (accept)
        begin
            count_reg   <= count_next;
            prev_nl_reg <= prev_nl_next;
            run_reg     <= run_next;
        end
    end

endmodule

@@ hdl/tscf_queue.sv @@
module tscf_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] head_data
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   fill_reg, fill_next;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ hdl/tscf_back.sv @@
module tscf_back #(
    parameter int COUNT_DIGITS = 8,
    parameter int MIN_WIDTH    = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  tscf_pkg::cmd_t                      head_cmd,
    input  logic [4*COUNT_DIGITS-1:0]           head_bcd,
    input  logic [$clog2(COUNT_DIGITS+1)-1:0]   head_sig,
    input  logic [$clog2(MIN_WIDTH+1)-1:0]      head_pad,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_byte,
    output logic                                last_in_run
);

    localparam int CNT_MAX = (COUNT_DIGITS > MIN_WIDTH) ? COUNT_DIGITS : MIN_WIDTH;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int DIG_W   = $clog2(COUNT_DIGITS);

    tscf_pkg::back_state_t state_reg, state_next, phase;

    logic [CNT_W-1:0] cnt_reg, cnt_next, idx, first_digit;
    logic [3:0]       digit_arr [COUNT_DIGITS];
    logic             fire, pad_end, digit_end, tail_end;
    logic [7:0]       byte_sel;
    logic             last_sel;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    always_comb
    begin
        for (int i = 0; i < COUNT_DIGITS; i++)
            digit_arr[i] = head_bcd[4*i +: 4];
    end

    assign first_digit = CNT_W'(head_sig - 1'b1);

    // At the head of an item, pick the first phase straight from the entry
    always_comb
    begin
        if (state_reg == tscf_pkg::ST_HEAD)
        begin
            if (!head_cmd.num)
            begin
                phase = tscf_pkg::ST_TAIL;
                idx   = '0;
            end
            else if (head_pad != '0)
            begin
                phase = tscf_pkg::ST_PAD;
                idx   = '0;
            end
            else
            begin
                phase = tscf_pkg::ST_DIGIT;
                idx   = first_digit;
            end
        end
        else
        begin
            phase = state_reg;
            idx   = cnt_reg;
        end
    end

    assign fire      = head_valid && (!out_valid_reg || out_ready);
    assign pad_end   = (idx == CNT_W'(head_pad - 1'b1));
    assign digit_end = (idx == '0);
    assign tail_end  = (head_cmd.tail_cnt == 2'd1) || idx[0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (fire)
        begin
            unique case (phase)
                tscf_pkg::ST_PAD:
                    state_next = pad_end ? tscf_pkg::ST_DIGIT : tscf_pkg::ST_PAD;
                tscf_pkg::ST_DIGIT:
                    state_next = digit_end ? tscf_pkg::ST_TAB : tscf_pkg::ST_DIGIT;
                tscf_pkg::ST_TAB:
                    state_next = (head_cmd.tail_cnt == 2'd0) ? tscf_pkg::ST_HEAD
                                                             : tscf_pkg::ST_TAIL;
                tscf_pkg::ST_TAIL:
                    state_next = tail_end ? tscf_pkg::ST_HEAD : tscf_pkg::ST_TAIL;
                default:
                    state_next = tscf_pkg::ST_HEAD;
            endcase
        end
    end

    // Byte, end-of-item flag and position counter
    always_comb
    begin
        byte_sel = tscf_pkg::CH_SPACE;
        last_sel = 1'b0;
        cnt_next = cnt_reg;
        unique case (phase)
            tscf_pkg::ST_PAD:
            begin
                byte_sel = tscf_pkg::CH_SPACE;
                cnt_next = pad_end ? first_digit : idx + 1'b1;
            end
            tscf_pkg::ST_DIGIT:
            begin
                byte_sel = tscf_pkg::CH_ZERO + {4'd0, digit_arr[idx[DIG_W-1:0]]};
                cnt_next = idx - 1'b1;
            end
            tscf_pkg::ST_TAB:
            begin
                byte_sel = tscf_pkg::CH_TAB;
                last_sel = (head_cmd.tail_cnt == 2'd0);
                cnt_next = '0;
            end
            tscf_pkg::ST_TAIL:
            begin
                byte_sel = idx[0] ? head_cmd.tail1 : head_cmd.tail0;
                last_sel = tail_end;
                cnt_next = idx + 1'b1;
            end
            default: ;
        endcase
        if (!fire)
            cnt_next = cnt_reg;
    end

    assign pop = fire && last_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tscf_pkg::ST_HEAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= last_sel;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_in_run = out_last_reg;

endmodule

@@ hdl/text_stream_cat_formatter.sv @@
// Text stream formatter after the cat filter's b, n, s, v, t and e options. Each input item is
// one raw byte; it yields zero or more output items, the final one flagged by last_in_run. A
// front end classifies the byte, keeps the line counter and squeeze state, and hands a short
// command to a two-entry queue; an output sequencer expands each command one byte per cycle,
// unless out_ready holds the output, into a registered output, so plain text streams at one
// item per cycle while the output is not stalled. A numbered line adds MAX(MIN_WIDTH,
// significant digits) + 1 bytes, caret forms and shown ends add one more. Input stalls only
// once the queue is full. An accepted byte is written into the queue, and its first output
// item is then presented through the output register. Configuration writes (index 0..5, bit
// 0 of cfg_data) are taken at once and must be made while the block is idle.
module text_stream_cat_formatter #(
    parameter int COUNT_DIGITS = 8,
    parameter int MIN_WIDTH    = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [tscf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             last_in_run
);

    localparam int BCD_W = 4 * COUNT_DIGITS;
    localparam int SIG_W = $clog2(COUNT_DIGITS + 1);
    localparam int PAD_W = $clog2(MIN_WIDTH + 1);
    localparam int QW    = $bits(tscf_pkg::cmd_t) + BCD_W + SIG_W + PAD_W;

    tscf_pkg::cmd_t   f_cmd, h_cmd;
    logic [BCD_W-1:0] f_bcd, h_bcd;
    logic [SIG_W-1:0] f_sig, h_sig;
    logic [PAD_W-1:0] f_pad, h_pad;
    logic             push, pop, full, head_valid;
    logic [QW-1:0]    push_data, head_data;

    tscf_front #(
        .COUNT_DIGITS (COUNT_DIGITS),
        .MIN_WIDTH    (MIN_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .queue_full   (full),
        .push         (push),
        .cmd          (f_cmd),
        .num_bcd      (f_bcd),
        .num_sig      (f_sig),
        .num_pad      (f_pad)
    );

    assign push_data = {f_cmd, f_bcd, f_sig, f_pad};

    tscf_queue #(
        .W (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign {h_cmd, h_bcd, h_sig, h_pad} = head_data;

    tscf_back #(
        .COUNT_DIGITS (COUNT_DIGITS),
        .MIN_WIDTH    (MIN_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (h_cmd),
        .head_bcd    (h_bcd),
        .head_sig    (h_sig),
        .head_pad    (h_pad),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_in_run (last_in_run)
    );

endmodule

@@ hdl/tscf_checker.sv @@
module tscf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_in_run
);

    // Nothing comes out in the cycle after a reset cycle
    a_quiet_in_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid after reset");

    // Hold a stalled output item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_in_run))
        else $error("stalled output item changed");

    // A newline only ever closes an item's run
    a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_byte == tscf_pkg::CH_NL |-> last_in_run)
        else $error("newline not at end of run");

    // A high byte passes through as the final byte of its run
    a_high_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_byte[7] |-> last_in_run)
        else $error("high byte not at end of run");

endmodule

bind text_stream_cat_formatter tscf_checker u_tscf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_in_run (last_in_run)
);
